[hdl/ppse_pkg.sv]
// Shared types and constants for the particle pool step engine.
// Used by ppse_step, particle_pool_step_engine_top and tb; no dependencies.
package ppse_pkg;

  localparam int unsigned POOL_SIZE = 64;
  localparam int unsigned SLOT_W    = $clog2(POOL_SIZE);
  localparam int unsigned LINK_W    = 7;
  localparam logic [LINK_W-1:0] LINK_NONE = 7'h7F;

  localparam int unsigned IN_DATA_W  = 336;
  localparam int unsigned OUT_DATA_W = 152;

  // Result kinds
  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_LIVE  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  // Operation codes
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
    logic [7:0]       opacity;
    logic [7:0]       fade;
    logic [7:0]       life;
    logic [39:0]      app;
  } slot_rec_t;

  typedef struct packed {
    logic      dead;
    slot_rec_t upd;
  } step_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SP_DIV,
    ST_SP_WR,
    ST_SP_RES,
    ST_TK_RD,
    ST_TK_EX,
    ST_TK_FREE,
    ST_TK_END
  } state_e;

endpackage

[hdl/ppse_step.sv]
// One tick of a single particle: fade, life count, motion update.
// Depends on ppse_pkg.
module ppse_step (
  input  ppse_pkg::slot_rec_t cur_i,
  output ppse_pkg::step_res_t res_o
);
  import ppse_pkg::*;

  logic [7:0] now;
  logic [7:0] life;

  // Fade and count down
  assign now  = cur_i.opacity - cur_i.fade;
  assign life = cur_i.life - 8'd1;

  // Flag expiry on wrap or end of life; advance position and velocity
  always_comb begin
    res_o.dead = (now > cur_i.opacity) || (life == 8'd0);
    res_o.upd = cur_i;
    res_o.upd.opacity = now;
    res_o.upd.life = life;
    for (int k = 0; k < 3; k++) begin
      res_o.upd.pos[k] = cur_i.pos[k] + cur_i.vel[k];
      res_o.upd.vel[k] = cur_i.vel[k] + cur_i.acc[k];
    end
  end

endmodule

[hdl/particle_pool_step_engine_top.sv]
// Particle pool step engine: top level with list control and storage.
// Depends on ppse_pkg and ppse_step.

// A spawn transaction makes one read of the link memory and an 8-step fade
// division, answering with one result. A tick transaction walks the active list
// through a single-port particle memory: read, then update and write back for a
// surviving particle (waiting while the held result cannot be released), plus a
// free-list push for an expiring one (the unlink writes the predecessor's link or
// the active head), then a last read and an end state. Results of a tick trail by
// one particle so that the final one can carry tlast. A new transaction is taken
// once the previous one is done; its final result may still wait in the output
// register. No clearing pass is needed after reset.
module particle_pool_step_engine_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, lifetime, appearance
  input  logic [ppse_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // operation
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // ok, slot, out_x, out_y, out_z, opacity, out_appearance, zero pad
  output logic [ppse_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // kind
  output logic [1:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import ppse_pkg::*;

  state_e state_q, state_d;

  logic [IN_DATA_W-1:0] in_q;
  logic [LINK_W-1:0] free_head_q, active_head_q, cur_q, prev_q, visits_q, sp_slot_q;
  logic [LINK_W-1:0] free_head_d, active_head_d, cur_d, prev_d, visits_d, sp_slot_d;
  logic sp_ok_q, sp_ok_d;
  logic [2:0] div_cnt_q;
  logic [7:0] rem_q, quo_q;
  logic [8:0] div_r;
  logic div_ge;
  logic [7:0] lt;

  // Particle memory
  slot_rec_t data_mem [POOL_SIZE];
  slot_rec_t data_rd_q, data_wdata;
  logic data_re, data_we;
  logic [SLOT_W-1:0] data_addr;

  // Link memory with reset-state valid bits
  logic [LINK_W-1:0] link_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] link_vld_q;
  logic [LINK_W-1:0] link_rd_mem_q, link_rd;
  logic [SLOT_W-1:0] link_rd_addr_q;
  logic link_rd_vld_q;
  logic link_re, link_we;
  logic [SLOT_W-1:0] link_raddr, link_waddr;
  logic [LINK_W-1:0] link_wdata;

  // Output and pending result
  logic out_valid_q, out_load, can_load;
  logic [1:0] out_kind_q, out_kind_d;
  logic out_ok_q, out_ok_d, out_last_q, out_last_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [2:0][31:0] out_pos_q, out_pos_d;
  logic [7:0] out_op_q, out_op_d;
  logic [39:0] out_app_q, out_app_d;

  logic pend_valid_q, pend_valid_d, pend_load;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [2:0][31:0] pend_pos_q;
  logic [7:0] pend_op_q;
  logic [39:0] pend_app_q;

  step_res_t step;
  logic accept, cur_end;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_load = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cur_end = (cur_q >= LINK_W'(POOL_SIZE)) || (visits_q == LINK_W'(POOL_SIZE));

  // Lifetime with zero treated as one
  assign lt = (in_q[295:288] == 8'd0) ? 8'd1 : in_q[295:288];
  assign div_r  = {rem_q, 1'b1};
  assign div_ge = div_r >= {1'b0, lt};

  // Link read data, unwritten entries read as their reset chain
  always_comb begin
    if (link_rd_vld_q) begin
      link_rd = link_rd_mem_q;
    end else if (link_rd_addr_q == SLOT_W'(POOL_SIZE - 1)) begin
      link_rd = LINK_NONE;
    end else begin
      link_rd = LINK_W'(link_rd_addr_q) + LINK_W'(1);
    end
  end

  ppse_step u_step (
    .cur_i (data_rd_q),
    .res_o (step)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == OP_TICK) begin
            state_d = ST_TK_RD;
          end else if (free_head_q >= LINK_W'(POOL_SIZE)) begin
            state_d = ST_SP_RES;
          end else begin
            state_d = ST_SP_DIV;
          end
        end
      end
      ST_SP_DIV:  if (div_cnt_q == 3'd7) state_d = ST_SP_WR;
      ST_SP_WR:   state_d = ST_SP_RES;
      ST_SP_RES:  if (can_load) state_d = ST_IDLE;
      ST_TK_RD:   state_d = cur_end ? ST_TK_END : ST_TK_EX;
      ST_TK_EX: begin
        if (step.dead) begin
          state_d = ST_TK_FREE;
        end else if (!pend_valid_q || can_load) begin
          state_d = ST_TK_RD;
        end
      end
      ST_TK_FREE: state_d = ST_TK_RD;
      ST_TK_END:  if (can_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control and datapath selection
  always_comb begin
    free_head_d   = free_head_q;
    active_head_d = active_head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    visits_d      = visits_q;
    sp_slot_d     = sp_slot_q;
    sp_ok_d       = sp_ok_q;
    data_re    = 1'b0;
    data_we    = 1'b0;
    data_addr  = cur_q[SLOT_W-1:0];
    data_wdata = step.upd;
    link_re    = 1'b0;
    link_raddr = cur_q[SLOT_W-1:0];
    link_we    = 1'b0;
    link_waddr = prev_q[SLOT_W-1:0];
    link_wdata = link_rd;
    out_load   = 1'b0;
    out_kind_d = KIND_LIVE;
    out_ok_d   = 1'b0;
    out_last_d = 1'b0;
    out_slot_d = pend_slot_q;
    out_pos_d  = pend_pos_q;
    out_op_d   = pend_op_q;
    out_app_d  = pend_app_q;
    pend_load    = 1'b0;
    pend_valid_d = pend_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cur_d      = active_head_q;
          prev_d     = LINK_NONE;
          visits_d   = '0;
          sp_ok_d    = 1'b0;
          sp_slot_d  = '0;
          link_re    = 1'b1;
          link_raddr = free_head_q[SLOT_W-1:0];
        end
      end
      ST_SP_WR: begin
        // Take the free head and push it on the active list
        data_we   = 1'b1;
        data_addr = free_head_q[SLOT_W-1:0];
        for (int k = 0; k < 3; k++) begin
          data_wdata.pos[k] = in_q[32*k +: 32];
          data_wdata.vel[k] = in_q[96 + 32*k +: 32];
          data_wdata.acc[k] = in_q[192 + 32*k +: 32];
        end
        data_wdata.opacity = 8'd255;
        data_wdata.fade    = quo_q;
        data_wdata.life    = lt;
        data_wdata.app     = in_q[335:296];
        link_we       = 1'b1;
        link_waddr    = free_head_q[SLOT_W-1:0];
        link_wdata    = active_head_q;
        free_head_d   = link_rd;
        active_head_d = free_head_q;
        sp_slot_d     = free_head_q;
        sp_ok_d       = 1'b1;
      end
      ST_SP_RES: begin
        out_load   = can_load;
        out_kind_d = KIND_SPAWN;
        out_ok_d   = sp_ok_q;
        out_last_d = 1'b1;
        out_slot_d = sp_slot_q[SLOT_W-1:0];
        out_pos_d  = '0;
        out_op_d   = '0;
        out_app_d  = '0;
      end
      ST_TK_RD: begin
        if (!cur_end) begin
          data_re = 1'b1;
          link_re = 1'b1;
        end
      end
      ST_TK_EX: begin
        if (step.dead) begin
          // Unlink from the predecessor
          visits_d = visits_q + LINK_W'(1);
          if (prev_q < LINK_W'(POOL_SIZE)) begin
            link_we = 1'b1;
          end else begin
            active_head_d = link_rd;
          end
        end else if (!pend_valid_q || can_load) begin
          // Write back, release the previous result, hold this one
          data_we      = 1'b1;
          out_load     = pend_valid_q;
          pend_load    = 1'b1;
          pend_valid_d = 1'b1;
          prev_d       = cur_q;
          cur_d        = link_rd;
          visits_d     = visits_q + LINK_W'(1);
        end
      end
      ST_TK_FREE: begin
        // Push the expired slot on the free list
        link_we     = 1'b1;
        link_waddr  = cur_q[SLOT_W-1:0];
        link_wdata  = free_head_q;
        free_head_d = cur_q;
        cur_d       = link_rd;
      end
      ST_TK_END: begin
        out_load   = can_load;
        out_last_d = 1'b1;
        if (!pend_valid_q) begin
          out_kind_d = KIND_NONE;
          out_slot_d = '0;
          out_pos_d  = '0;
          out_op_d   = '0;
          out_app_d  = '0;
        end
        if (can_load) pend_valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      free_head_q   <= '0;
      active_head_q <= LINK_NONE;
      cur_q         <= LINK_NONE;
      prev_q        <= LINK_NONE;
      visits_q      <= '0;
      sp_slot_q     <= '0;
      sp_ok_q       <= 1'b0;
      div_cnt_q     <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      link_vld_q    <= '0;
    end else begin
      state_q       <= state_d;
      free_head_q   <= free_head_d;
      active_head_q <= active_head_d;
      cur_q         <= cur_d;
      prev_q        <= prev_d;
      visits_q      <= visits_d;
      sp_slot_q     <= sp_slot_d;
      sp_ok_q       <= sp_ok_d;
      pend_valid_q  <= pend_valid_d;
      div_cnt_q     <= (state_q == ST_SP_DIV) ? div_cnt_q + 3'd1 : 3'd0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (link_we) link_vld_q[link_waddr] <= 1'b1;
    end
  end

  // Input capture and fade division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= s_axis_tdata_i;
    if (state_q == ST_SP_DIV) begin
      rem_q <= div_ge ? 8'(div_r - {1'b0, lt}) : div_r[7:0];
      quo_q <= {quo_q[6:0], div_ge};
    end else begin
      rem_q <= '0;
      quo_q <= '0;
    end
  end

  // Particle memory
  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_addr] <= data_wdata;
    if (data_re) data_rd_q <= data_mem[data_addr];
  end

  // Link memory
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_re) begin
      link_rd_mem_q  <= link_mem[link_raddr];
      link_rd_addr_q <= link_raddr;
      link_rd_vld_q  <= link_vld_q[link_raddr];
    end
  end

  // Pending and output payload
  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_slot_q <= cur_q[SLOT_W-1:0];
      pend_pos_q  <= step.upd.pos;
      pend_op_q   <= step.upd.opacity;
      pend_app_q  <= step.upd.app;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_ok_q   <= out_ok_d;
      out_last_q <= out_last_d;
      out_slot_q <= out_slot_d;
      out_pos_q  <= out_pos_d;
      out_op_q   <= out_op_d;
      out_app_q  <= out_app_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_app_q, out_op_q, out_pos_q[2], out_pos_q[1],
                            out_pos_q[0], 6'(out_slot_q), out_ok_q};

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for particle_pool_step_engine_top: spawn and tick streams
// checked against an in-bench model of the particle pool. Depends on ppse_pkg.
`timescale 1ns / 1ps

module tb;
  import ppse_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [5:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  opacity;
    logic [39:0] app;
    logic        last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  particle_pool_step_engine_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always #5 clk_i = ~clk_i;

  // Pool shadow state
  logic [2:0][31:0] pool_pos [POOL_SIZE];
  logic [2:0][31:0] pool_vel [POOL_SIZE];
  logic [2:0][31:0] pool_acc [POOL_SIZE];
  logic [7:0]  pool_opac [POOL_SIZE];
  logic [7:0]  pool_fade [POOL_SIZE];
  logic [7:0]  pool_life [POOL_SIZE];
  logic [39:0] pool_app  [POOL_SIZE];
  logic [6:0]  pool_link [POOL_SIZE];
  logic [6:0]  active_head;
  logic [6:0]  free_head;

  result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned n_spawn = 0, n_tick = 0, n_results = 0, n_full = 0;
  int unsigned tx_idle_pct = 0, rx_idle_pct = 0;

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void pool_reset();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_pos[i] = '0; pool_vel[i] = '0; pool_acc[i] = '0;
      pool_opac[i] = '0; pool_fade[i] = '0; pool_life[i] = '0; pool_app[i] = '0;
      pool_link[i] = (i + 1 < POOL_SIZE) ? 7'(i + 1) : LINK_NONE;
    end
    active_head = LINK_NONE;
    free_head = '0;
  endfunction

  // Advance the pool by one accepted transaction and queue its results
  function automatic void pool_predict(input logic op, input logic [IN_DATA_W-1:0] d);
    result_t r;
    logic [6:0] s, cur, prev, nxt;
    logic [5:0] si, ci;
    logic [7:0] lt, old_o, now_o, life;
    int n, visits;
    r = '0;
    if (op == OP_SPAWN) begin
      n_spawn++;
      r.kind = KIND_SPAWN;
      r.last = 1'b1;
      if (free_head < POOL_SIZE) begin
        s = free_head;
        si = s[5:0];
        free_head = pool_link[si];
        pool_link[si] = active_head;
        active_head = s;
        for (int k = 0; k < 3; k++) begin
          pool_pos[si][k] = d[32*k +: 32];
          pool_vel[si][k] = d[96 + 32*k +: 32];
          pool_acc[si][k] = d[192 + 32*k +: 32];
        end
        lt = d[295:288];
        if (lt == 0) lt = 8'd1;
        pool_opac[si] = 8'd255;
        pool_fade[si] = 8'(255 / lt);
        pool_life[si] = lt;
        pool_app[si] = d[335:296];
        r.ok = 1'b1;
        r.slot = si;
      end else begin
        n_full++;
      end
      pending_results.push_back(r);
      return;
    end
    n_tick++;
    n = 0; visits = 0;
    prev = LINK_NONE;
    cur = active_head;
    while (cur < POOL_SIZE && visits < POOL_SIZE) begin
      ci = cur[5:0];
      nxt = pool_link[ci];
      old_o = pool_opac[ci];
      now_o = old_o - pool_fade[ci];
      life = pool_life[ci] - 8'd1;
      visits++;
      pool_opac[ci] = now_o;
      pool_life[ci] = life;
      if (old_o < now_o || life == 0) begin
        // Unlink and return to the free list
        pool_pos[ci] = '0; pool_vel[ci] = '0; pool_acc[ci] = '0;
        pool_opac[ci] = '0; pool_fade[ci] = '0; pool_life[ci] = '0;
        pool_app[ci] = '0;
        if (prev < POOL_SIZE) pool_link[prev[5:0]] = nxt;
        else active_head = nxt;
        pool_link[ci] = free_head;
        free_head = cur;
      end else begin
        for (int k = 0; k < 3; k++) begin
          pool_pos[ci][k] = pool_pos[ci][k] + pool_vel[ci][k];
          pool_vel[ci][k] = pool_vel[ci][k] + pool_acc[ci][k];
        end
        r = '0;
        r.kind = KIND_LIVE;
        r.slot = ci;
        r.x = pool_pos[ci][0]; r.y = pool_pos[ci][1]; r.z = pool_pos[ci][2];
        r.opacity = now_o;
        r.app = pool_app[ci];
        pending_results.push_back(r);
        n++;
        prev = cur;
      end
      cur = nxt;
    end
    if (n == 0) begin
      r = '0;
      r.kind = KIND_NONE;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = m_axis_tuser_o;
      got.ok = m_axis_tdata_o[0];
      got.slot = m_axis_tdata_o[6:1];
      got.x = m_axis_tdata_o[38:7];
      got.y = m_axis_tdata_o[70:39];
      got.z = m_axis_tdata_o[102:71];
      got.opacity = m_axis_tdata_o[110:103];
      got.app = m_axis_tdata_o[150:111];
      got.last = m_axis_tlast_o;
      n_results++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d slot %0d", got.kind, got.slot));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.ok !== want.ok) report($sformatf("ok %0b, want %0b", got.ok, want.ok));
        if (got.slot !== want.slot)
          report($sformatf("slot %0d, want %0d", got.slot, want.slot));
        if (got.x !== want.x) report($sformatf("x %h, want %h", got.x, want.x));
        if (got.y !== want.y) report($sformatf("y %h, want %h", got.y, want.y));
        if (got.z !== want.z) report($sformatf("z %h, want %h", got.z, want.z));
        if (got.opacity !== want.opacity)
          report($sformatf("opacity %0d, want %0d", got.opacity, want.opacity));
        if (got.app !== want.app) report($sformatf("app %h, want %h", got.app, want.app));
        if (got.last !== want.last)
          report($sformatf("tlast %0b, want %0b", got.last, want.last));
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Drive one transaction; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] d);
    s_axis_tuser_i = op;
    s_axis_tdata_i = d;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pool_predict(op, d);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] spawn_data(input logic [7:0] lt);
    logic [IN_DATA_W-1:0] d;
    for (int k = 0; k < 9; k++) d[32*k +: 32] = rand_word();
    d[295:288] = lt;
    d[335:296] = {8'($urandom_range(255)), $urandom};
    return d;
  endfunction

  task automatic spawn(input logic [7:0] lt);
    send_item(OP_SPAWN, spawn_data(lt));
  endtask

  task automatic tick();
    send_item(OP_TICK, {IN_DATA_W{1'b0}} | {$urandom, $urandom});
  endtask

  // Extremes of every field, empty-pool tick, short and long lives
  task automatic test_directed();
    logic [IN_DATA_W-1:0] d;
    tick();
    send_item(OP_SPAWN, {8'd1, {9{32'h0}}} | {40'h0, 8'h0, 288'h0});
    d = {40'hFF_FFFF_FFFF, 8'd255, {9{32'hFFFF_FFFF}}};
    send_item(OP_SPAWN, d);
    d = {40'h0, 8'd3, {3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}};
    send_item(OP_SPAWN, d);
    spawn(8'd0);
    spawn(8'd2);
    spawn(8'd128);
    repeat (4) tick();
    spawn(8'd1);
    repeat (3) tick();
  endtask

  // Fill the pool to overflow, then tick, spawn once more and tick again
  task automatic test_pool_full();
    repeat (POOL_SIZE + 3) spawn(8'($urandom_range(200, 255)));
    tick();
    spawn(8'd5);
    repeat (3) tick();
  endtask

  // Random mix: mostly spawns with short lives, some ticks
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 35) tick();
      else if ($urandom_range(9) == 0) spawn(8'($urandom));
      else spawn(8'($urandom_range(1, 12)));
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    pool_reset();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    tx_idle_pct = 21; rx_idle_pct = 85;
    test_random(50);
    test_pool_full();
    tx_idle_pct = 85; rx_idle_pct = 21;
    test_random(50);
    tx_idle_pct = 0; rx_idle_pct = 0;
    test_random(50);
    test_pool_full();
    wait_drained();
    $display("covered %0d spawns (%0d refused as full), %0d ticks, %0d results checked",
             n_spawn, n_full, n_tick, n_results);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
